### hw/rtl/lmcd_pkg.sv
`default_nettype none

package lmcd_pkg;

    // Commands carried by the cmd field of an input word.
    typedef enum logic [1:0] {
        CMD_SET_PIXEL = 2'd0,
        CMD_REFRESH   = 2'd1,
        CMD_INIT      = 2'd2,
        CMD_OPEN_LINE = 2'd3
    } cmd_t;

    // Result kinds.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_RESET = 2'd0;
    localparam kind_t KIND_DOT   = 2'd1;
    localparam kind_t KIND_PIXEL = 2'd2;
    localparam kind_t KIND_LINE  = 2'd3;

    localparam int          BYTE_W     = 8;
    localparam int          COLOURS    = 3;
    localparam int          PIXEL_W    = COLOURS * BYTE_W;
    localparam int          DOT_WORDS  = 24;
    localparam logic [7:0]  DOT_WORD   = 8'h3F;
    localparam logic [3:0]  BITS_NONE  = 4'd0;
    localparam logic [3:0]  BITS_DOT   = 4'd6;
    localparam logic [3:0]  BITS_PIXEL = 4'd8;

    // Colour slots within one pixel, in shift order.
    localparam logic [1:0]  SLOT_BLUE  = 2'd0;
    localparam logic [1:0]  SLOT_GREEN = 2'd1;
    localparam logic [1:0]  SLOT_RED   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_INIT
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/lmcd_ram.sv
`default_nettype none

module lmcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lmcd_frame.sv
`default_nettype none

module lmcd_frame #(
    parameter int DEPTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  wire logic [lmcd_pkg::PIXEL_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic      [lmcd_pkg::PIXEL_W-1:0] rd_data
);

    import lmcd_pkg::*;

    // One flag per pixel: a pixel never written since reset reads as zero.
    logic [DEPTH-1:0]   valid_reg;
    logic               rd_valid_reg;
    logic [PIXEL_W-1:0] ram_q;

    lmcd_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? ram_q : '0;

endmodule

`default_nettype wire

### hw/rtl/led_matrix_column_driver.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      cmd, column, row, red, green, blue, line
// result    out        strobe, one cycle each    kind, word, word_bits, latch_pulse,
//                                                bank_select, line_mask, last
//
// Set pixel writes the frame store in the accept cycle and leaves busy low. Open line
// gives its single word in the cycle after accept and also leaves busy low. Refresh
// column is busy over its rows, each a frame store read and then blue, green and red
// words, so the single-port read sets the pace. Init gives a reset word and DOT_WORDS
// dot words, one word per cycle. Reset clears the frame store at once through per-pixel
// flags. The receiver cannot stall: each word is presented for exactly one cycle.

module led_matrix_column_driver #(
    parameter int MATRIX_SIZE = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] cmd,
    input  wire logic [2:0] column,
    input  wire logic [2:0] row,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    input  wire logic [3:0] line,
    output logic            strobe,
    output logic [1:0]      kind,
    output logic [7:0]      word,
    output logic [3:0]      word_bits,
    output logic            latch_pulse,
    output logic            bank_select,
    output logic [7:0]      line_mask,
    output logic            last
);

    import lmcd_pkg::*;

    localparam int PIXELS = MATRIX_SIZE * MATRIX_SIZE;
    localparam int AW     = $clog2(PIXELS);
    localparam int RW     = $clog2(MATRIX_SIZE);
    localparam int IW     = $clog2(DOT_WORDS + 1);

    localparam logic [RW-1:0] LAST_ROW = RW'(MATRIX_SIZE - 1);
    localparam logic [IW-1:0] LAST_DOT = IW'(DOT_WORDS);

    // Sequencer state. All of these are control and are cleared by reset.
    state_t        state_reg,  state_next;
    logic [2:0]    col_reg,    col_next;
    logic [RW-1:0] row_reg,    row_next;
    logic [1:0]    slot_reg,   slot_next;
    logic [IW-1:0] step_reg,   step_next;
    logic [7:0]    lines_reg,  lines_next;
    logic          bank_reg,   bank_next;
    logic          strobe_reg, strobe_next;

    // Result payload registers.
    kind_t         kind_reg,   kind_next;
    logic [7:0]    word_reg,   word_next;
    logic [3:0]    bits_reg,   bits_next;
    logic          latch_reg,  latch_next;
    logic          last_reg,   last_next;

    // Frame store port signals.
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [PIXEL_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [PIXEL_W-1:0] pixel;

    logic in_range_set;
    logic in_range_col;

    lmcd_frame #(
        .DEPTH (PIXELS)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (pixel)
    );

    // Coordinates past the matrix edge only occur for matrices below 8x8.
    assign in_range_col = int'(column) < MATRIX_SIZE;
    assign in_range_set = in_range_col && (int'(row) < MATRIX_SIZE);

    // Pixels are stored column-major, one word of blue, green and red each.
    assign wr_addr = AW'(int'(column) * MATRIX_SIZE + int'(row));
    assign wr_data = {red, green, blue};
    assign rd_addr = AW'(int'(col_reg) * MATRIX_SIZE + int'(row_reg));

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        slot_next   = slot_reg;
        step_next   = step_reg;
        lines_next  = lines_reg;
        bank_next   = bank_reg;
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        word_next   = 8'd0;
        bits_next   = BITS_NONE;
        latch_next  = 1'b0;
        last_next   = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_SET_PIXEL:
                        begin
                            wr_en = in_range_set;
                        end
                        CMD_REFRESH:
                        begin
                            if (in_range_col)
                            begin
                                col_next   = column;
                                row_next   = '0;
                                state_next = ST_READ;
                            end
                        end
                        CMD_INIT:
                        begin
                            lines_next = 8'd0;
                            bank_next  = 1'b0;
                            step_next  = '0;
                            state_next = ST_INIT;
                        end
                        CMD_OPEN_LINE:
                        begin
                            // A line number above 7 closes every line.
                            if (line[3])
                            begin
                                lines_next = 8'd0;
                            end
                            else
                            begin
                                lines_next = lines_reg | (8'd1 << line[2:0]);
                            end
                            strobe_next = 1'b1;
                            kind_next   = KIND_LINE;
                            last_next   = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                slot_next  = SLOT_BLUE;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_PIXEL;
                bits_next   = BITS_PIXEL;
                case (slot_reg)
                    SLOT_BLUE:  word_next = pixel[7:0];
                    SLOT_GREEN: word_next = pixel[15:8];
                    SLOT_RED:   word_next = pixel[23:16];
                    default:    word_next = 8'd0;
                endcase
                if (slot_reg == SLOT_RED)
                begin
                    if (row_reg == LAST_ROW)
                    begin
                        // The latch pulse comes with the final byte of the column.
                        latch_next = 1'b1;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            ST_INIT:
            begin
                strobe_next = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == '0)
                begin
                    kind_next = KIND_RESET;
                end
                else
                begin
                    kind_next = KIND_DOT;
                    word_next = DOT_WORD;
                    bits_next = BITS_DOT;
                end
                if (step_reg == LAST_DOT)
                begin
                    // Bank select rises together with the last correction word.
                    bank_next  = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
            step_reg   <= '0;
            lines_reg  <= '0;
            bank_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            slot_reg   <= slot_next;
            step_reg   <= step_next;
            lines_reg  <= lines_next;
            bank_reg   <= bank_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        word_reg  <= word_next;
        bits_reg  <= bits_next;
        latch_reg <= latch_next;
        last_reg  <= last_next;
    end

    // Bank select and the line mask are shown as they stand after each word.
    assign strobe      = strobe_reg;
    assign kind        = kind_reg;
    assign word        = word_reg;
    assign word_bits   = bits_reg;
    assign latch_pulse = latch_reg;
    assign bank_select = bank_reg;
    assign line_mask   = lines_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

### tb/led_matrix_column_driver_checker.sv
`default_nettype none

module led_matrix_column_driver_checker
    import lmcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [1:0] cmd,
    input  wire logic [2:0] column,
    input  wire logic [2:0] row,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    input  wire logic [3:0] line,
    input  wire logic       strobe,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] word,
    input  wire logic [3:0] word_bits,
    input  wire logic       latch_pulse,
    input  wire logic       bank_select,
    input  wire logic [7:0] line_mask,
    input  wire logic       last,
    input  wire logic       drain_check,
    output int              failures,
    output int              words_checked,
    output int              outstanding
);

    localparam int SIDE = 8;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [3:0] bits;
        logic       latch;
        logic       bank;
        logic [7:0] mask;
        logic       fin;
    } out_word_t;

    logic [7:0] pixel_bytes [0:SIDE*SIDE*COLOURS-1];
    logic [7:0] open_lines;
    logic       bank_level;
    out_word_t  expected_words [$];
    int         errors;
    int         seen;
    logic       leftovers_flagged;

    function automatic void queue_word(kind_t k, logic [7:0] v, logic [3:0] b,
                                       logic lat, logic fin);
        expected_words.push_back('{k, v, b, lat, bank_level, open_lines, fin});
    endfunction

    // Applies one accepted command to the shadow state and queues its words.
    function automatic void forecast_words(logic [1:0] c, logic [2:0] col,
                                           logic [2:0] r, logic [7:0] rd,
                                           logic [7:0] gr, logic [7:0] bl,
                                           logic [3:0] ln);
        int base;
        base = (int'(col) * SIDE + int'(r)) * COLOURS;
        case (cmd_t'(c))
            CMD_SET_PIXEL:
            begin
                pixel_bytes[base + SLOT_BLUE]  = bl;
                pixel_bytes[base + SLOT_GREEN] = gr;
                pixel_bytes[base + SLOT_RED]   = rd;
            end
            CMD_REFRESH:
            begin
                for (int i = 0; i < SIDE * COLOURS; i++)
                    queue_word(KIND_PIXEL, pixel_bytes[int'(col) * SIDE * COLOURS + i],
                               BITS_PIXEL, i == SIDE * COLOURS - 1,
                               i == SIDE * COLOURS - 1);
            end
            CMD_INIT:
            begin
                open_lines = 8'h00;
                bank_level = 1'b0;
                queue_word(KIND_RESET, 8'h00, BITS_NONE, 1'b0, 1'b0);
                for (int i = 0; i < DOT_WORDS; i++)
                begin
                    if (i == DOT_WORDS - 1)
                        bank_level = 1'b1;
                    queue_word(KIND_DOT, DOT_WORD, BITS_DOT, 1'b0, i == DOT_WORDS - 1);
                end
            end
            default:
            begin
                if (ln <= 4'd7)
                    open_lines = open_lines | (8'h01 << ln);
                else
                    open_lines = 8'h00;
                queue_word(KIND_LINE, 8'h00, BITS_NONE, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp;
        if (!rst_n)
        begin
            for (int i = 0; i < SIDE * SIDE * COLOURS; i++)
                pixel_bytes[i] = 8'h00;
            open_lines = 8'h00;
            bank_level = 1'b0;
            expected_words.delete();
            errors = 0;
            seen = 0;
            leftovers_flagged = 1'b0;
        end
        else
        begin
            // Words on the output belong to commands accepted at earlier edges,
            // so they are checked before this edge's command is forecast.
            if (strobe)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: kind %0d word %0d", kind, word);
                    errors++;
                end
                else
                begin
                    exp = expected_words.pop_front();
                    seen++;
                    compare_field("kind", 8'(exp.kind), 8'(kind));
                    compare_field("word", exp.value, word);
                    compare_field("word_bits", 8'(exp.bits), 8'(word_bits));
                    compare_field("latch_pulse", 8'(exp.latch), 8'(latch_pulse));
                    compare_field("bank_select", 8'(exp.bank), 8'(bank_select));
                    compare_field("line_mask", exp.mask, line_mask);
                    compare_field("last", 8'(exp.fin), 8'(last));
                end
            end
            if (start && !busy)
                forecast_words(cmd, column, row, red, green, blue, line);
            if (drain_check && !leftovers_flagged)
            begin
                if (expected_words.size() != 0)
                begin
                    $error("%0d expected words never arrived", expected_words.size());
                    errors++;
                end
                leftovers_flagged = 1'b1;
            end
        end
        failures      <= errors;
        words_checked <= seen;
        outstanding   <= expected_words.size();
    end

endmodule

`default_nettype wire

### tb/led_matrix_column_driver_test.sv
`default_nettype none

// Top of the testbench for the LED matrix column driver. It makes the command
// stimulus and gives the verdict; the checker beside the block watches both
// channels, keeps a shadow frame store, line mask and bank select level, and
// compares every result word with what it predicts.

module led_matrix_column_driver_test;
    import lmcd_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] cmd = CMD_SET_PIXEL;
    logic [2:0] column = 3'd0;
    logic [2:0] row = 3'd0;
    logic [7:0] red = 8'd0;
    logic [7:0] green = 8'd0;
    logic [7:0] blue = 8'd0;
    logic [3:0] line = 4'd0;
    logic       drain_check = 1'b0;

    logic       busy;
    logic       strobe;
    logic [1:0] kind;
    logic [7:0] word;
    logic [3:0] word_bits;
    logic       latch_pulse;
    logic       bank_select;
    logic [7:0] line_mask;
    logic       last;

    int failures;
    int words_checked;
    int outstanding;

    // Gaps between commands are on by default; a middle stretch of the random
    // part turns them off so that commands arrive back to back.
    logic gaps_on = 1'b1;
    int   cmd_count [4];

    always #6 clk = ~clk;

    led_matrix_column_driver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .column      (column),
        .row         (row),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .line        (line),
        .strobe      (strobe),
        .kind        (kind),
        .word        (word),
        .word_bits   (word_bits),
        .latch_pulse (latch_pulse),
        .bank_select (bank_select),
        .line_mask   (line_mask),
        .last        (last)
    );

    led_matrix_column_driver_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .column        (column),
        .row           (row),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .line          (line),
        .strobe        (strobe),
        .kind          (kind),
        .word          (word),
        .word_bits     (word_bits),
        .latch_pulse   (latch_pulse),
        .bank_select   (bank_select),
        .line_mask     (line_mask),
        .last          (last),
        .drain_check   (drain_check),
        .failures      (failures),
        .words_checked (words_checked),
        .outstanding   (outstanding)
    );

    // Drives one command word and returns at the edge that accepts it. The
    // caller is always at a rising edge, so every assignment here lands at an
    // edge. Random idle cycles come first, and start stays low during them.
    // Busy is read right after the edge, which still shows its value from
    // before the edge, the same value the block used to accept or refuse.
    task automatic send_command(cmd_t c, logic [2:0] col, logic [2:0] r,
                                logic [7:0] rd, logic [7:0] gr, logic [7:0] bl,
                                logic [3:0] ln);
        while (gaps_on && $urandom_range(0, 99) < 28)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        cmd    <= c;
        column <= col;
        row    <= r;
        red    <= rd;
        green  <= gr;
        blue   <= bl;
        line   <= ln;
        do
            @(posedge clk);
        while (busy);
        cmd_count[c]++;
    endtask

    // Random commands lean toward pixel writes, which fill the frame store so
    // that refreshes read back varied data. Every field carries random content
    // even where the command ignores it.
    task automatic send_random_command();
        int   pick;
        cmd_t c;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c = CMD_SET_PIXEL;
        else if (pick < 70)
            c = CMD_REFRESH;
        else if (pick < 90)
            c = CMD_OPEN_LINE;
        else
            c = CMD_INIT;
        send_command(c, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
    endtask

    initial
    begin
        int drain_cycles;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A refresh straight after reset must read the cleared frame store.
        send_command(CMD_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 4'd0);
        // Open the lowest and highest lines, then let init clear the mask.
        send_command(CMD_OPEN_LINE, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 4'd0);
        send_command(CMD_OPEN_LINE, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF, 4'd7);
        send_command(CMD_INIT, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF, 4'd15);
        // A line above 7 clears every line, both at the low and the top end.
        send_command(CMD_OPEN_LINE, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 4'd3);
        send_command(CMD_OPEN_LINE, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 4'd8);
        send_command(CMD_OPEN_LINE, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 4'd5);
        send_command(CMD_OPEN_LINE, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 4'd15);
        // Pixels at the four corners with extreme and alternating bytes.
        send_command(CMD_SET_PIXEL, 3'd0, 3'd0, 8'hFF, 8'h00, 8'hAA, 4'd0);
        send_command(CMD_SET_PIXEL, 3'd0, 3'd7, 8'h01, 8'h80, 8'h55, 4'd0);
        send_command(CMD_SET_PIXEL, 3'd7, 3'd0, 8'hFF, 8'hFF, 8'hFF, 4'd15);
        send_command(CMD_SET_PIXEL, 3'd7, 3'd7, 8'h80, 8'h7F, 8'h01, 4'd15);
        send_command(CMD_REFRESH, 3'd0, 3'd5, 8'h00, 8'h00, 8'h00, 4'd0);
        send_command(CMD_REFRESH, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00, 4'd0);
        // An open line and two inits while bank select is still high after init.
        send_command(CMD_OPEN_LINE, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 4'd6);
        send_command(CMD_INIT, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 4'd0);
        send_command(CMD_INIT, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 4'd0);
        // Init leaves the frame store alone, so this refresh shows old pixels.
        send_command(CMD_REFRESH, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00, 4'd0);
        // Overwrite a pixel and read its column again.
        send_command(CMD_SET_PIXEL, 3'd7, 3'd7, 8'h00, 8'h00, 8'h00, 4'd0);
        send_command(CMD_REFRESH, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00, 4'd0);

        for (int i = 0; i < 450; i++)
        begin
            gaps_on <= !(i >= 150 && i < 300);
            send_random_command();
        end
        start <= 1'b0;

        // Wait until the checker has no expected word outstanding, then leave a margin
        // for anything still in flight before the drain check.
        drain_cycles = 0;
        while (outstanding != 0 && drain_cycles < 5000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (40) @(posedge clk);
        drain_check <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Sent %0d pixel writes, %0d refreshes, %0d inits and %0d line opens;",
                 cmd_count[CMD_SET_PIXEL], cmd_count[CMD_REFRESH],
                 cmd_count[CMD_INIT], cmd_count[CMD_OPEN_LINE]);
        $display("compared %0d result words field by field.", words_checked);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // This time limit lies far above what the whole run needs.
    initial
    begin
        #6000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/lmcd_pkg.sv
hw/rtl/lmcd_ram.sv
hw/rtl/lmcd_frame.sv
hw/rtl/led_matrix_column_driver.sv
tb/led_matrix_column_driver_checker.sv
tb/led_matrix_column_driver_test.sv
